FILE: src/rbp_pkg.sv
// Shared types and constants for the reference-counted buffer pool.
// Holds the request/response structs, codes and pool geometry.
// No dependencies; every other file in src imports it.
package rbp_pkg;

  // Pool geometry
  localparam int unsigned POOL_DEPTH  = 32;
  localparam int unsigned DATA_BYTES  = 4096;
  localparam int unsigned ALIGN_BYTES = 64;

  localparam int unsigned IDX_W   = $clog2(POOL_DEPTH);
  localparam int unsigned TOTAL_W = $clog2(POOL_DEPTH + 1);
  localparam int unsigned REFC_W  = 8;
  localparam int unsigned ADDR_W  = 32;

  localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(DATA_BYTES + ALIGN_BYTES);
  localparam logic [ADDR_W-1:0] ALIGN_MASK  = ADDR_W'(ALIGN_BYTES - 1);
  localparam logic [REFC_W-1:0] REFC_MAX    = '1;

  // Configuration port
  localparam int unsigned PADDR_W      = 3;
  localparam logic [0:0]  REG_POOL_BASE = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_ADD_REF = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_EMPTY      = 2'd1,
    STATUS_NOT_IN_USE = 2'd2,
    STATUS_OVERFLOW   = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [IDX_W-1:0] buffer_index;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   granted_index;
    logic [ADDR_W-1:0]  buffer_address;
    logic               returned_to_pool;
    logic [REFC_W-1:0]  reference_count;
    logic [TOTAL_W-1:0] free_buffers;
  } rsp_t;

  // Classified command passed from front to back
  typedef struct packed {
    opcode_t          kind;
    logic [IDX_W-1:0] idx;
    logic             in_pool;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_ADDR
  } back_state_t;

endpackage

FILE: src/rbp_front.sv
// Front end of the buffer pool: accepts requests, classifies them and
// queues them in a two-entry FIFO for the back end. Depends on rbp_pkg.
module rbp_front import rbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W   = $clog2(Q_DEPTH + 1);

  cmd_t             entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  cmd_t             cmd_in;
  logic             push;
  logic             pop;

  // Classify the incoming request
  always_comb begin
    cmd_in.kind    = req.opcode;
    cmd_in.idx     = req.buffer_index;
    cmd_in.in_pool = ((IDX_W + 1)'(req.buffer_index) < (IDX_W + 1)'(POOL_DEPTH));
  end

  assign req_ready = (fill != CNT_W'(Q_DEPTH));
  assign push      = req_valid && req_ready;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = entries[rd_ptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: src/rbp_back.sv
// Back end of the buffer pool: free stack and reference count memories,
// the execute sequencer and the response register. Depends on rbp_pkg.
module rbp_back import rbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] pool_base,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp
);

  back_state_t state, state_next;

  // Memories and their per-entry valid bits
  logic [REFC_W-1:0] cnt_mem [POOL_DEPTH];
  logic [IDX_W-1:0]  stk_mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] cnt_vld;
  logic [POOL_DEPTH-1:0] stk_vld;

  logic [REFC_W-1:0] cnt_rd;
  logic              cnt_rd_vld;
  logic [IDX_W-1:0]  stk_rd;
  logic              stk_rd_vld;

  logic [TOTAL_W-1:0] free_total, free_total_next;
  cmd_t               cur;
  logic [IDX_W-1:0]   top_pos;

  // Execute results
  logic               rd_en;
  logic               exec_en;
  logic               load;
  logic [REFC_W-1:0]  cur_cnt;
  logic [IDX_W-1:0]   top_idx;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [REFC_W-1:0]  cnt_wdata;
  logic               stk_we;
  status_t            ex_status;
  logic [IDX_W-1:0]   ex_idx;
  logic               ex_ret;
  logic [REFC_W-1:0]  ex_cnt;
  logic               ex_addr_en;

  status_t            res_status;
  logic [IDX_W-1:0]   res_idx;
  logic               res_ret;
  logic [REFC_W-1:0]  res_cnt;
  logic               res_addr_en;

  logic [ADDR_W-1:0]  slot_addr;
  logic [ADDR_W-1:0]  data_addr;

  assign top_pos = free_total[IDX_W-1:0] - 1'b1;
  assign cur_cnt = cnt_rd_vld ? cnt_rd : '0;
  assign top_idx = stk_rd_vld ? stk_rd : top_pos;

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    rd_en      = 1'b0;
    exec_en    = 1'b0;
    load       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          rd_en      = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        exec_en    = 1'b1;
        state_next = BK_ADDR;
      end
      BK_ADDR: begin
        if (!rsp_valid || rsp_ready) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the command under execution
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur <= cmd;
    end
  end

  // Execute one operation on the read data
  always_comb begin
    free_total_next = free_total;
    cnt_we     = 1'b0;
    cnt_waddr  = cur.idx;
    cnt_wdata  = cur_cnt;
    stk_we     = 1'b0;
    ex_status  = STATUS_OK;
    ex_idx     = cur.idx;
    ex_ret     = 1'b0;
    ex_cnt     = '0;
    ex_addr_en = 1'b0;
    unique case (cur.kind) inside
      OP_ALLOC: begin
        ex_idx = '0;
        if (free_total == '0 || free_total > TOTAL_W'(POOL_DEPTH)) begin
          ex_status = STATUS_EMPTY;
        end else begin
          free_total_next = free_total - 1'b1;
          ex_idx     = top_idx;
          ex_cnt     = REFC_W'(1);
          ex_addr_en = 1'b1;
          cnt_we     = 1'b1;
          cnt_waddr  = top_idx;
          cnt_wdata  = REFC_W'(1);
        end
      end
      OP_ADD_REF, OP_RELEASE: begin
        if (!cur.in_pool) begin
          ex_status = STATUS_NOT_IN_USE;
        end else begin
          ex_addr_en = 1'b1;
          if (cur_cnt == '0) begin
            ex_status = STATUS_NOT_IN_USE;
          end else if (cur.kind == OP_ADD_REF) begin
            if (cur_cnt == REFC_MAX) begin
              ex_status = STATUS_OVERFLOW;
              ex_cnt    = cur_cnt;
            end else begin
              ex_cnt    = cur_cnt + 1'b1;
              cnt_we    = 1'b1;
              cnt_wdata = cur_cnt + 1'b1;
            end
          end else begin
            ex_cnt    = cur_cnt - 1'b1;
            cnt_we    = 1'b1;
            cnt_wdata = cur_cnt - 1'b1;
            if (cur_cnt == REFC_W'(1) && free_total < TOTAL_W'(POOL_DEPTH)) begin
              stk_we          = 1'b1;
              ex_ret          = 1'b1;
              free_total_next = free_total + 1'b1;
            end
          end
        end
      end
      OP_NOP: begin
        if (cur.in_pool) begin
          ex_addr_en = 1'b1;
          ex_cnt     = cur_cnt;
        end
      end
      default: ex_status = STATUS_OK;
    endcase
  end

  // Memory reads and writes
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_rd <= cnt_mem[cmd.idx];
      stk_rd <= stk_mem[top_pos];
    end
    if (exec_en && cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (exec_en && stk_we) begin
      stk_mem[free_total[IDX_W-1:0]] <= cur.idx;
    end
  end

  // Valid bits: unwritten counts read zero, unwritten stack slots read their position
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld    <= '0;
      stk_vld    <= '0;
      cnt_rd_vld <= 1'b0;
      stk_rd_vld <= 1'b0;
      free_total <= TOTAL_W'(POOL_DEPTH);
    end else begin
      if (rd_en) begin
        cnt_rd_vld <= cnt_vld[cmd.idx];
        stk_rd_vld <= stk_vld[top_pos];
      end
      if (exec_en && cnt_we) begin
        cnt_vld[cnt_waddr] <= 1'b1;
      end
      if (exec_en && stk_we) begin
        stk_vld[free_total[IDX_W-1:0]] <= 1'b1;
      end
      if (exec_en) begin
        free_total <= free_total_next;
      end
    end
  end

  // Latch execute results
  always_ff @(posedge clk) begin
    if (exec_en) begin
      res_status  <= ex_status;
      res_idx     <= ex_idx;
      res_ret     <= ex_ret;
      res_cnt     <= ex_cnt;
      res_addr_en <= ex_addr_en;
    end
  end

  // Slot start and aligned data address
  assign slot_addr = pool_base + ADDR_W'(res_idx) * SLOT_STRIDE;
  assign data_addr = (slot_addr + ALIGN_MASK) & ~ALIGN_MASK;

  // Response register
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status           <= res_status;
      rsp.granted_index    <= res_idx;
      rsp.buffer_address   <= res_addr_en ? data_addr : '0;
      rsp.returned_to_pool <= res_ret;
      rsp.reference_count  <= res_cnt;
      rsp.free_buffers     <= free_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= TOTAL_W'(POOL_DEPTH))
    else $error("free buffer total exceeds pool depth");

  a_alloc_pops: assert property (@(posedge clk) disable iff (rst)
    (exec_en && cur.kind == OP_ALLOC && free_total != '0)
      |=> free_total == $past(free_total) - 1'b1)
    else $error("allocate did not pop the free stack");

  a_return_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.returned_to_pool)
      |-> (rsp.status == STATUS_OK && rsp.reference_count == '0))
    else $error("buffer returned with nonzero count");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STATUS_EMPTY)
      |-> (rsp.granted_index == '0 && rsp.free_buffers == '0))
    else $error("empty-pool response carries a grant");

endmodule

FILE: src/refcounted_buffer_pool_core.sv
// Top level of the reference-counted buffer pool allocator.
// Holds the configuration register; instantiates rbp_front and rbp_back.
// Depends on rbp_pkg.
//
// Buffer pool with a LIFO free stack and an 8-bit reference count per
// buffer. Each request (allocate, add reference, release) produces exactly
// one response carrying the status, the buffer index, its aligned data
// address pool_base + index * (DATA_BYTES + ALIGN_BYTES) rounded up to
// ALIGN_BYTES, the resulting count and the number of free buffers. Requests
// enter a two-entry queue and are executed one at a time: the back end
// performs the memory read, then execute and write back, then address
// formation into the response register, and takes no new request until the
// response is loaded. A waiting response stalls the back end; the queue
// still accepts requests until its two entries are full. Write pool_base only
// while no request is in flight.
module refcounted_buffer_pool_core import rbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  // Response channel
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [ADDR_W-1:0] pool_base;
  logic              cfg_wr;
  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_POOL_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_wr) begin
      pool_base <= pwdata;
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_POOL_BASE) ? pool_base : '0;

  rbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  rbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pool_base (pool_base),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
